// ===== hdl/dpu_pkg.sv =====
`default_nettype none
package dpu_pkg;

    localparam logic [23:0] FULL_SCALE = 24'hFFFFFF;

    localparam int QUO_W   = 32;   // quotient bits per divider
    localparam int NUM_W   = 45;   // signed pixel offset numerator
    localparam int MAG_W   = 44;   // its magnitude
    localparam int DXY_W   = 44;   // image size times focal term
    localparam int ZDIV_W  = 57;   // eye depth divisor
    localparam int XDIV_W  = 60;   // upper dividend bits of the x/y divide

    localparam int FQ_DEPTH = 4;
    localparam int FQ_PTR_W = 2;

    localparam logic [2:0] CFG_NEAR_PLANE  = 3'd0;
    localparam logic [2:0] CFG_FAR_PLANE   = 3'd1;
    localparam logic [2:0] CFG_FOCAL_X     = 3'd2;
    localparam logic [2:0] CFG_FOCAL_Y     = 3'd3;
    localparam logic [2:0] CFG_CENTER_X    = 3'd4;
    localparam logic [2:0] CFG_CENTER_Y    = 3'd5;
    localparam logic [2:0] CFG_MODEL_SCALE = 3'd6;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    typedef struct packed {
        logic [23:0] depth;
        logic [7:0]  col;
        logic [7:0]  row;
        t_color      color;
    } t_pixel;

    typedef struct packed {
        logic [31:0]        near_plane;
        logic [31:0]        far_plane;
        logic [31:0]        focal_x;
        logic [31:0]        focal_y;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [31:0]        model_scale;
    } t_cfg;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        t_color      color;
    } t_point;

endpackage
`default_nettype wire

// ===== hdl/dpu_front.sv =====
`default_nettype none
module dpu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dpu_pkg::t_pixel i_pix,
    output logic            o_full,
    output logic            o_vld,
    output dpu_pkg::t_pixel o_pix,
    input  logic            i_take
);
    import dpu_pkg::*;

    t_pixel              r_q [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] r_rp;
    logic [FQ_PTR_W-1:0] r_wp;
    logic [FQ_PTR_W:0]   r_cnt;
    logic                keep;
    logic                wr;
    logic                rd;

    // background pixels are accepted and dropped here
    assign keep   = (i_pix.depth != 24'd0) && (i_pix.depth != FULL_SCALE);
    assign o_full = (r_cnt == (FQ_PTR_W+1)'(FQ_DEPTH));
    assign wr     = i_push && !o_full && keep;
    assign rd     = i_take && o_vld;
    assign o_vld  = (r_cnt != '0);
    assign o_pix  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp  <= '0;
            r_wp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_pix;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/dpu_div.sv =====
`default_nettype none
module dpu_div #(
    parameter int W    = 57,
    parameter int SB_W = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [W+dpu_pkg::QUO_W-1:0] i_num,
    input  logic [W-1:0]               i_den,
    input  logic [SB_W-1:0]            i_sb,
    output logic                       o_vld,
    output logic                       o_ovf,
    output logic [dpu_pkg::QUO_W-1:0]  o_quo,
    output logic [SB_W-1:0]            o_sb
);
    import dpu_pkg::*;

    localparam int NS = QUO_W + 1;

    logic [NS-1:0]    r_vld;
    logic [W-1:0]     r_rem [NS];
    logic [W-1:0]     r_den [NS];
    logic [QUO_W-1:0] r_w   [NS];
    logic             r_ovf [NS];
    logic [SB_W-1:0]  r_sb  [NS];
    logic [W-1:0]     n_rem [NS];
    logic [QUO_W-1:0] n_w   [NS];
    logic [W:0]       c_t   [QUO_W];
    logic             c_ge  [QUO_W];

    // stage 0 catches quotients of 2^32 and up; the rest is one restoring step each
    always_comb begin
        n_rem[0] = i_num[W+QUO_W-1:QUO_W];
        n_w[0]   = i_num[QUO_W-1:0];
        for (int k = 0; k < QUO_W; k++) begin
            c_t[k]     = {r_rem[k], r_w[k][QUO_W-1]};
            c_ge[k]    = (c_t[k] >= {1'b0, r_den[k]});
            n_rem[k+1] = c_ge[k] ? W'(c_t[k] - {1'b0, r_den[k]}) : W'(c_t[k]);
            n_w[k+1]   = {r_w[k][QUO_W-2:0], c_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem[0];
            r_w[0]   <= n_w[0];
            r_den[0] <= i_den;
            r_ovf[0] <= (i_num[W+QUO_W-1:QUO_W] >= i_den);
            r_sb[0]  <= i_sb;
            for (int k = 1; k < NS; k++) begin
                r_rem[k] <= n_rem[k];
                r_w[k]   <= n_w[k];
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
                r_sb[k]  <= r_sb[k-1];
            end
        end
    end

    assign o_vld = r_vld[NS-1];
    assign o_ovf = r_ovf[NS-1];
    assign o_quo = r_w[NS-1];
    assign o_sb  = r_sb[NS-1];

endmodule
`default_nettype wire

// ===== hdl/dpu_back.sv =====
`default_nettype none
module dpu_back #(
    parameter int IMAGE_WIDTH  = 256,
    parameter int IMAGE_HEIGHT = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dpu_pkg::t_cfg   i_cfg,
    input  logic            i_vld,
    input  dpu_pkg::t_pixel i_pix,
    output logic            o_take,
    output logic            o_empty,
    input  logic            i_pop,
    output dpu_pkg::t_point o_point
);
    import dpu_pkg::*;

    localparam logic signed [NUM_W-1:0] SIZE_X = NUM_W'(IMAGE_WIDTH);
    localparam logic signed [NUM_W-1:0] SIZE_Y = NUM_W'(IMAGE_HEIGHT);
    localparam int XSB_W = 24 + 32 + 1;
    localparam int ZSB_W = 24 + 16;

    function automatic logic [31:0] f_sat(input logic neg, input logic ovf,
                                          input logic [31:0] q);
        logic [31:0] res;
        if (neg) begin
            res = (ovf || q > 32'h80000000) ? 32'h80000000 : (~q + 32'd1);
        end else begin
            res = (ovf || q > 32'h7FFFFFFF) ? 32'h7FFFFFFF : q;
        end
        return res;
    endfunction

    logic adv;
    logic pop_fire;

    // config-derived terms
    logic signed [NUM_W-1:0] r_cxw;
    logic signed [NUM_W-1:0] r_cyw;
    logic [DXY_W-1:0]        r_dx;
    logic [DXY_W-1:0]        r_dy;

    // S1, S2
    logic        r_s1_vld;
    logic [63:0] r_nf;
    logic [55:0] r_pf;
    logic [55:0] r_pn;
    t_pixel      r_s1_pix;
    logic        r_s2_vld;
    logic [ZDIV_W-1:0] r_den;
    logic [87:0] r_nfs;
    t_pixel      r_s2_pix;

    // eye depth divide
    logic             zd_vld;
    logic             zd_ovf;
    logic [QUO_W-1:0] zd_quo;
    logic [ZSB_W-1:0] zd_sb;
    logic [31:0]      z;
    t_color           zd_color;
    logic [7:0]       zd_col;
    logic [7:0]       zd_row;

    // SP
    logic        r_sp_vld;
    logic [63:0] r_sp_p;
    logic signed [NUM_W-1:0] r_numx;
    logic signed [NUM_W-1:0] r_numy;
    t_color      r_sp_color;
    logic signed [NUM_W-1:0] ax;
    logic signed [NUM_W-1:0] ay;

    // SQ
    logic             r_sq_vld;
    logic [63:0]      r_sq_p;
    logic [MAG_W-1:0] r_magx;
    logic [MAG_W-1:0] r_magy;
    logic             r_sq_negx;
    logic             r_sq_negy;
    logic [31:0]      r_sq_pz;
    t_color           r_sq_color;
    logic [47:0]      zs;

    // SPP
    logic        r_pp_vld;
    logic [63:0] r_x00, r_x01, r_y00, r_y01;
    logic [43:0] r_x10, r_x11, r_y10, r_y11;
    logic        r_pp_negx;
    logic        r_pp_negy;
    logic [31:0] r_pp_pz;
    t_color      r_pp_color;

    // SM
    logic        r_sm_vld;
    logic [63:0] r_sm_x00, r_sm_y00;
    logic [43:0] r_sm_x11, r_sm_y11;
    logic [64:0] r_xmid, r_ymid;
    logic        r_sm_negx;
    logic        r_sm_negy;
    logic [31:0] r_sm_pz;
    t_color      r_sm_color;
    logic [107:0] ax_full;
    logic [107:0] ay_full;

    // x/y divides
    logic             xd_vld;
    logic             xd_ovf;
    logic [QUO_W-1:0] xd_quo;
    logic [XSB_W-1:0] xd_sb;
    logic             yd_vld;
    logic             yd_ovf;
    logic [QUO_W-1:0] yd_quo;
    logic             yd_negy;
    logic             pt_vld;
    t_point           res;

    // result queue
    t_point      r_ofifo [2];
    logic        r_orp;
    logic        r_owp;
    logic [1:0]  r_ocnt;
    logic        ofull;

    assign pt_vld   = xd_vld && yd_vld;
    assign ofull    = (r_ocnt == 2'd2);
    assign o_empty  = (r_ocnt == 2'd0);
    assign pop_fire = i_pop && !o_empty;
    // the whole back pipeline moves together; it holds only when a finished point can't land
    assign adv      = !pt_vld || !ofull || pop_fire;
    assign o_take   = i_vld && adv;
    assign o_point  = r_ofifo[r_orp];

    always_ff @(posedge i_clk) begin
        r_cxw <= NUM_W'(i_cfg.center_x) * SIZE_X;
        r_cyw <= NUM_W'(i_cfg.center_y) * SIZE_Y;
        r_dx  <= DXY_W'(i_cfg.focal_x) * DXY_W'(IMAGE_WIDTH);
        r_dy  <= DXY_W'(i_cfg.focal_y) * DXY_W'(IMAGE_HEIGHT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_sp_vld <= 1'b0;
            r_sq_vld <= 1'b0;
            r_pp_vld <= 1'b0;
            r_sm_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= o_take;
            r_s2_vld <= r_s1_vld;
            r_sp_vld <= zd_vld;
            r_sq_vld <= r_sp_vld;
            r_pp_vld <= r_sq_vld;
            r_sm_vld <= r_pp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_nf     <= 64'(i_cfg.near_plane) * 64'(i_cfg.far_plane);
            r_pf     <= 56'(i_cfg.far_plane) * 56'(FULL_SCALE - i_pix.depth);
            r_pn     <= 56'(i_pix.depth) * 56'(i_cfg.near_plane);
            r_s1_pix <= i_pix;

            r_den    <= ZDIV_W'(r_pf) + ZDIV_W'(r_pn);
            r_nfs    <= {r_nf, 24'd0} - 88'(r_nf);
            r_s2_pix <= r_s1_pix;
        end
    end

    dpu_div #(.W(ZDIV_W), .SB_W(ZSB_W)) u_zdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_s2_vld),
        .i_num   ({1'b0, r_nfs}),
        .i_den   (r_den),
        .i_sb    ({r_s2_pix.color, r_s2_pix.col, r_s2_pix.row}),
        .o_vld   (zd_vld),
        .o_ovf   (zd_ovf),
        .o_quo   (zd_quo),
        .o_sb    (zd_sb)
    );

    assign {zd_color, zd_col, zd_row} = zd_sb;

    always_comb begin
        // divisor is zero only when both planes are zero
        if (i_cfg.near_plane == 32'd0 && i_cfg.far_plane == 32'd0) begin
            z = 32'd0;
        end else if (zd_ovf) begin
            z = 32'hFFFFFFFF;
        end else begin
            z = zd_quo;
        end
        ax = $signed(NUM_W'({zd_col, 1'b0})) - SIZE_X;
        ay = $signed(NUM_W'({zd_row, 1'b0})) - SIZE_Y;
        zs = r_sp_p[63:16];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sp_p     <= 64'(z) * 64'(i_cfg.model_scale);
            r_numx     <= (ax <<< 16) - r_cxw;
            r_numy     <= (ay <<< 16) - r_cyw;
            r_sp_color <= zd_color;

            r_sq_p     <= r_sp_p;
            r_magx     <= MAG_W'(r_numx[NUM_W-1] ? -r_numx : r_numx);
            r_magy     <= MAG_W'(r_numy[NUM_W-1] ? -r_numy : r_numy);
            r_sq_negx  <= r_numx[NUM_W-1];
            r_sq_negy  <= r_numy[NUM_W-1];
            if (zs == 48'd0) begin
                r_sq_pz <= 32'd0;
            end else if (zs > 48'h80000000) begin
                r_sq_pz <= 32'h80000000;
            end else begin
                r_sq_pz <= 32'(48'd0 - zs);
            end
            r_sq_color <= r_sp_color;

            // 44 x 64 products split into 32-bit partials
            r_x00      <= 64'(r_magx[31:0]) * 64'(r_sq_p[31:0]);
            r_x01      <= 64'(r_magx[31:0]) * 64'(r_sq_p[63:32]);
            r_x10      <= 44'(r_magx[43:32]) * 44'(r_sq_p[31:0]);
            r_x11      <= 44'(r_magx[43:32]) * 44'(r_sq_p[63:32]);
            r_y00      <= 64'(r_magy[31:0]) * 64'(r_sq_p[31:0]);
            r_y01      <= 64'(r_magy[31:0]) * 64'(r_sq_p[63:32]);
            r_y10      <= 44'(r_magy[43:32]) * 44'(r_sq_p[31:0]);
            r_y11      <= 44'(r_magy[43:32]) * 44'(r_sq_p[63:32]);
            r_pp_negx  <= r_sq_negx;
            r_pp_negy  <= r_sq_negy;
            r_pp_pz    <= r_sq_pz;
            r_pp_color <= r_sq_color;

            r_sm_x00   <= r_x00;
            r_sm_x11   <= r_x11;
            r_xmid     <= 65'(r_x01) + 65'(r_x10);
            r_sm_y00   <= r_y00;
            r_sm_y11   <= r_y11;
            r_ymid     <= 65'(r_y01) + 65'(r_y10);
            r_sm_negx  <= r_pp_negx;
            r_sm_negy  <= r_pp_negy;
            r_sm_pz    <= r_pp_pz;
            r_sm_color <= r_pp_color;
        end
    end

    assign ax_full = {r_sm_x11, r_sm_x00} + {11'd0, r_xmid, 32'd0};
    assign ay_full = {r_sm_y11, r_sm_y00} + {11'd0, r_ymid, 32'd0};

    // the 2^16 in the divisor is taken off the dividend first
    dpu_div #(.W(XDIV_W), .SB_W(XSB_W)) u_xdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_sm_vld),
        .i_num   (ax_full[107:16]),
        .i_den   (XDIV_W'(r_dx)),
        .i_sb    ({r_sm_color, r_sm_pz, r_sm_negx}),
        .o_vld   (xd_vld),
        .o_ovf   (xd_ovf),
        .o_quo   (xd_quo),
        .o_sb    (xd_sb)
    );

    dpu_div #(.W(XDIV_W), .SB_W(1)) u_ydiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_sm_vld),
        .i_num   (ay_full[107:16]),
        .i_den   (XDIV_W'(r_dy)),
        .i_sb    (r_sm_negy),
        .o_vld   (yd_vld),
        .o_ovf   (yd_ovf),
        .o_quo   (yd_quo),
        .o_sb    (yd_negy)
    );

    always_comb begin
        res.color = xd_sb[XSB_W-1:33];
        res.z     = xd_sb[32:1];
        res.x     = (i_cfg.focal_x == 32'd0) ? 32'd0 : f_sat(xd_sb[0], xd_ovf, xd_quo);
        res.y     = (i_cfg.focal_y == 32'd0) ? 32'd0 : f_sat(yd_negy, yd_ovf, yd_quo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orp  <= 1'b0;
            r_owp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (pt_vld && adv) begin
                r_owp <= ~r_owp;
            end
            if (pop_fire) begin
                r_orp <= ~r_orp;
            end
            if (pt_vld && adv && !pop_fire) begin
                r_ocnt <= r_ocnt + 2'd1;
            end else if (pop_fire && !(pt_vld && adv)) begin
                r_ocnt <= r_ocnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pt_vld && adv) begin
            r_ofifo[r_owp] <= res;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/depth_pixel_to_point_unprojection.sv =====
// Depth pixel to 3-D point unprojection.
// Input channel: queue style, a pixel transaction completes when push is high and
// full is low. Pixels at depth zero or full scale are taken and dropped.
// Result channel: queue style, the oldest point is on o_point_* / o_*_out while
// empty is low; it is consumed when pop is high.
// Config channel: i_cfg_valid/o_cfg_ready with a register index and 32-bit data;
// ready is always high. Write only while the block is idle.
// Throughput: one pixel per clock while each finished point can land in the result
// queue. A pixel passes the input queue, then the back end, a 72-stage pipeline whose
// length is set by two 33-stage restoring divides in series (eye depth, then x and y
// side by side), each retiring one quotient bit per stage after its overflow stage.
// Reset: synchronous, active low; clears all queues and loads the default camera.
// Stall: the result queue holds two points; beyond that the back pipeline freezes,
// the four-entry input queue fills and full rises. Nothing is lost.
`default_nettype none
module depth_pixel_to_point_unprojection #(
    parameter int IMAGE_WIDTH  = 256,
    parameter int IMAGE_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [23:0] i_depth_value,
    input  logic [7:0]  i_pixel_column,
    input  logic [7:0]  i_pixel_row,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out
);
    import dpu_pkg::*;

    t_cfg   r_cfg;
    t_pixel in_pix;
    t_pixel q_pix;
    t_point point;
    logic   q_vld;
    logic   q_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_plane  <= 32'd6554;
            r_cfg.far_plane   <= 32'd209715;
            r_cfg.focal_x     <= 32'd65536;
            r_cfg.focal_y     <= 32'd65536;
            r_cfg.center_x    <= 32'sd0;
            r_cfg.center_y    <= 32'sd0;
            r_cfg.model_scale <= 32'd65536;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NEAR_PLANE:  r_cfg.near_plane  <= i_cfg_data;
                CFG_FAR_PLANE:   r_cfg.far_plane   <= i_cfg_data;
                CFG_FOCAL_X:     r_cfg.focal_x     <= i_cfg_data;
                CFG_FOCAL_Y:     r_cfg.focal_y     <= i_cfg_data;
                CFG_CENTER_X:    r_cfg.center_x    <= $signed(i_cfg_data);
                CFG_CENTER_Y:    r_cfg.center_y    <= $signed(i_cfg_data);
                CFG_MODEL_SCALE: r_cfg.model_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_pix.depth       = i_depth_value;
    assign in_pix.col         = i_pixel_column;
    assign in_pix.row         = i_pixel_row;
    assign in_pix.color.red   = i_red_in;
    assign in_pix.color.green = i_green_in;
    assign in_pix.color.blue  = i_blue_in;

    dpu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pix   (in_pix),
        .o_full  (full),
        .o_vld   (q_vld),
        .o_pix   (q_pix),
        .i_take  (q_take)
    );

    dpu_back #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (q_vld),
        .i_pix   (q_pix),
        .o_take  (q_take),
        .o_empty (empty),
        .i_pop   (pop),
        .o_point (point)
    );

    assign o_point_x   = point.x;
    assign o_point_y   = point.y;
    assign o_point_z   = point.z;
    assign o_red_out   = point.color.red;
    assign o_green_out = point.color.green;
    assign o_blue_out  = point.color.blue;

endmodule
`default_nettype wire

// ===== hdl/dpu_checker.sv =====
`default_nettype none
module dpu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic [23:0] i_depth_value,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_point_x,
    input logic [31:0] o_point_y,
    input logic [31:0] o_point_z
);

    // the input queue only fills from pushes
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without a push transaction");

    // background pixels never take a queue slot
    a_drop_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && (i_depth_value == 24'd0 || i_depth_value == 24'hFFFFFF))
        |=> !full)
        else $error("dropped pixel filled the input queue");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result vanished");

    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> ($stable(o_point_x) && $stable(o_point_y)
                              && $stable(o_point_z)))
        else $error("waiting result changed");

endmodule

bind depth_pixel_to_point_unprojection dpu_checker u_dpu_checker (.*);
`default_nettype wire

// ===== dv/depth_pixel_to_point_unprojection_tb.sv =====
`default_nettype none
module depth_pixel_to_point_unprojection_tb;
    import dpu_pkg::*;

    localparam int IMG_W = 256;
    localparam int IMG_H = 256;
    localparam int PIPE_LAT = 80;
    localparam int STALL_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [23:0] i_depth_value = '0;
    logic [7:0]  i_pixel_column = '0;
    logic [7:0]  i_pixel_row = '0;
    logic [7:0]  i_red_in = '0;
    logic [7:0]  i_green_in = '0;
    logic [7:0]  i_blue_in = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic signed [31:0] o_point_x, o_point_y, o_point_z;
    logic [7:0]  o_red_out, o_green_out, o_blue_out;

    depth_pixel_to_point_unprojection #(.IMAGE_WIDTH(IMG_W), .IMAGE_HEIGHT(IMG_H)) dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_cfg   camera;
    t_point expected_points[$];
    int     n_errors = 0;
    int     n_points = 0;
    int     n_dropped = 0;
    int     n_cfg_writes = 0;
    int     idle_cycles = 0;
    int     pop_hold = 0;
    bit     quiet = 1'b0;
    bit     sender_gaps = 1'b1;

    // ---------------- predictor ----------------
    function automatic logic [31:0] eye_depth(input logic [23:0] d);
        logic [127:0] den, numr, q;
        den = 128'(camera.far_plane) * 128'(FULL_SCALE - d) + 128'(d) * 128'(camera.near_plane);
        if (den == 0) return 32'd0;
        numr = 128'(camera.near_plane) * 128'(camera.far_plane) * 128'(FULL_SCALE);
        q = numr / den;
        return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic logic [31:0] clamp_q(input bit neg, input logic [127:0] q);
        if (neg) begin
            if (q > 128'h8000_0000) return 32'h8000_0000;
            return -q[31:0];
        end
        if (q > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic logic [31:0] unproject_axis(input logic [7:0] idx, input int sz,
            input logic signed [31:0] ctr, input logic [31:0] focal, input logic [31:0] z);
        longint num;
        logic [63:0] mag;
        logic [127:0] prod, q;
        if (focal == 0) return 32'd0;
        num = (2 * longint'(idx) - longint'(sz)) * 65536 - longint'(ctr) * longint'(sz);
        mag = (num < 0) ? 64'(-num) : 64'(num);
        prod = 128'(mag) * 128'(z) * 128'(camera.model_scale);
        q = prod / (128'(sz) * 128'(focal) * 128'd65536);
        return clamp_q(num < 0, q);
    endfunction

    function automatic void predict_point(input logic [23:0] d, input logic [7:0] col,
            input logic [7:0] row, input t_color c);
        t_point p;
        logic [31:0] z;
        logic [63:0] zs;
        if (d == 24'd0 || d == FULL_SCALE) begin
            n_dropped++;
            return;
        end
        z = eye_depth(d);
        zs = (64'(z) * 64'(camera.model_scale)) >> 16;
        p.x = unproject_axis(col, IMG_W, camera.center_x, camera.focal_x, z);
        p.y = unproject_axis(row, IMG_H, camera.center_y, camera.focal_y, z);
        p.z = clamp_q(zs != 0, 128'(zs));
        p.color = c;
        expected_points = {expected_points, p};
    endfunction

    // ---------------- point checker ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_points.size() == 0) begin
                $error("unexpected point x=%h y=%h z=%h", o_point_x, o_point_y, o_point_z);
                n_errors++;
            end else begin
                t_point e;
                e = expected_points.pop_front();
                n_points++;
                if (o_point_x !== e.x) begin
                    $error("point_x exp %h got %h", e.x, o_point_x); n_errors++;
                end
                if (o_point_y !== e.y) begin
                    $error("point_y exp %h got %h", e.y, o_point_y); n_errors++;
                end
                if (o_point_z !== e.z) begin
                    $error("point_z exp %h got %h", e.z, o_point_z); n_errors++;
                end
                if (o_red_out !== e.color.red) begin
                    $error("red_out exp %h got %h", e.color.red, o_red_out); n_errors++;
                end
                if (o_green_out !== e.color.green) begin
                    $error("green_out exp %h got %h", e.color.green, o_green_out); n_errors++;
                end
                if (o_blue_out !== e.color.blue) begin
                    $error("blue_out exp %h got %h", e.color.blue, o_blue_out); n_errors++;
                end
            end
        end
    end

    // ---------------- receiver ----------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (pop_hold > 0) begin
                pop <= 1'b0;
                repeat (pop_hold - 1) @(posedge i_clk);
                pop_hold = 0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog: cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("depth_pixel_to_point_unprojection verification failed");
            $finish;
        end
    end

    // ---------------- sender ----------------
    task automatic send_pixel(input logic [23:0] d, input logic [7:0] col,
            input logic [7:0] row, input t_color c);
        push <= 1'b1;
        i_depth_value <= d;
        i_pixel_column <= col;
        i_pixel_row <= row;
        {i_red_in, i_green_in, i_blue_in} <= c;
        do @(posedge i_clk); while (full);
        predict_point(d, col, row, c);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        n_cfg_writes++;
        case (idx)
            CFG_NEAR_PLANE:  camera.near_plane = val;
            CFG_FAR_PLANE:   camera.far_plane = val;
            CFG_FOCAL_X:     camera.focal_x = val;
            CFG_FOCAL_Y:     camera.focal_y = val;
            CFG_CENTER_X:    camera.center_x = val;
            CFG_CENTER_Y:    camera.center_y = val;
            CFG_MODEL_SCALE: camera.model_scale = val;
            default: ;
        endcase
    endtask

    task automatic set_camera(input t_cfg c);
        write_reg(CFG_NEAR_PLANE, c.near_plane);
        write_reg(CFG_FAR_PLANE, c.far_plane);
        write_reg(CFG_FOCAL_X, c.focal_x);
        write_reg(CFG_FOCAL_Y, c.focal_y);
        write_reg(CFG_CENTER_X, c.center_x);
        write_reg(CFG_CENTER_Y, c.center_y);
        write_reg(CFG_MODEL_SCALE, c.model_scale);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_color rand_color();
        return t_color'($urandom);
    endfunction

    function automatic logic [23:0] rand_depth();
        case ($urandom_range(0, 9))
            0: return 24'd0;
            1: return FULL_SCALE;
            2: return 24'(FULL_SCALE - $urandom_range(1, 64));
            3: return 24'($urandom_range(1, 64));
            default: return 24'($urandom_range(1, 24'hFFFFFE));
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(1, 255);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
            2: return $urandom_range(32'h1000, 32'h40000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cfg rand_camera();
        t_cfg c;
        if ($urandom_range(0, 2) != 0) begin
            // typical camera: near below far, modest focal and scale
            c.near_plane  = $urandom_range(256, 32'h20000);
            c.far_plane   = c.near_plane + $urandom_range(1, 32'h1000000);
            c.focal_x     = $urandom_range(32'h4000, 32'h40000);
            c.focal_y     = $urandom_range(32'h4000, 32'h40000);
            c.center_x    = $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
            c.center_y    = $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
            c.model_scale = $urandom_range(32'h100, 32'h80000);
        end else begin
            c.near_plane  = rand_word();
            c.far_plane   = rand_word();
            c.focal_x     = rand_word();
            c.focal_y     = rand_word();
            c.center_x    = $urandom;
            c.center_y    = $urandom;
            c.model_scale = rand_word();
        end
        return c;
    endfunction

    // ---------------- tests ----------------
    task automatic test_default_camera();
        logic [23:0] depths[6] = '{24'd1, 24'hFFFFFE, 24'd0, 24'hFFFFFF, 24'h800000, 24'hFFF000};
        logic [7:0]  coords[3] = '{8'd0, 8'd255, 8'd128};
        foreach (depths[k])
            send_pixel(depths[k], coords[k % 3], coords[(k + 1) % 3], rand_color());
        send_pixel(24'h123456, 8'd0, 8'd0, t_color'(24'h000000));
        send_pixel(24'h654321, 8'd255, 8'd255, t_color'(24'hFFFFFF));
        send_pixel(24'hAAAAAA, 8'h55, 8'hAA, t_color'(24'h55AA55));
        send_pixel(24'h555555, 8'hAA, 8'h55, t_color'(24'hAA55AA));
        wait_drained();
    endtask

    task automatic test_camera_extremes();
        t_cfg cams[5];
        // both planes zero, both focal terms zero
        cams[0] = '{32'd0, 32'd0, 32'd0, 32'd0, 32'sd0, 32'sd0, 32'd65536};
        // everything at its maximum, far equal to near
        cams[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF};
        // far below near, smallest nonzero focal, most negative centers
        cams[2] = '{32'h0010_0000, 32'd1, 32'd1, 32'd1,
                    32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF};
        // zero model scale
        cams[3] = '{32'd1, 32'hFFFF_FFFF, 32'd65536, 32'd65536, -32'sd65536, 32'sd65536, 32'd0};
        cams[4] = '{32'd6554, 32'd209715, 32'd65536, 32'd65536, 32'sd0, 32'sd0, 32'd65536};
        foreach (cams[k]) begin
            set_camera(cams[k]);
            send_pixel(24'd1, 8'd0, 8'd255, rand_color());
            send_pixel(24'hFFFFFE, 8'd255, 8'd0, rand_color());
            send_pixel(24'h800000, 8'd128, 8'd128, rand_color());
            send_pixel(24'($urandom_range(1, 24'hFFFFFE)), 8'($urandom), 8'($urandom),
                       rand_color());
            wait_drained();
        end
    endtask

    task automatic test_random_cameras(input int n_items);
        int sent = 0;
        while (sent < n_items) begin
            set_camera(rand_camera());
            repeat ($urandom_range(40, 200)) begin
                send_pixel(rand_depth(), 8'($urandom), 8'($urandom), rand_color());
                sent++;
            end
            wait_drained();
        end
    endtask

    // enough pixels to fill the whole back pipeline and the input queue
    task automatic test_backpressure();
        pop_hold = 400;
        sender_gaps = 1'b0;
        repeat (200) send_pixel(rand_depth(), 8'($urandom), 8'($urandom), rand_color());
        sender_gaps = 1'b1;
        wait_drained();
    endtask

    task automatic test_full_rate();
        quiet = 1'b1;
        sender_gaps = 1'b0;
        set_camera(rand_camera());
        repeat (150) send_pixel(rand_depth(), 8'($urandom), 8'($urandom), rand_color());
        wait_drained();
    endtask

    initial begin
        camera = '{32'd6554, 32'd209715, 32'd65536, 32'd65536, 32'sd0, 32'sd0, 32'd65536};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_camera();
        test_camera_extremes();
        test_backpressure();
        test_random_cameras(1400);
        test_full_rate();
        $display("Covered %0d points and %0d dropped background pixels", n_points, n_dropped);
        $display("over %0d register writes, with stalls on both sides", n_cfg_writes);
        if (n_errors == 0 && expected_points.size() == 0)
            $display("depth_pixel_to_point_unprojection verification clean");
        else
            $display("depth_pixel_to_point_unprojection verification failed");
        $finish;
    end
endmodule
`default_nettype wire
